@@ sv/tlmh_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and codes for the two-lane 64-bit mixing hash
// no dependencies

package tlmh_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;

    // per-lane mixing constants
    localparam logic [WORD_W-1:0] MIX_L0_A = 64'h6D3BCCC3981F33CE;
    localparam logic [WORD_W-1:0] MIX_L0_B = 64'h0B9AEE71139AB058;
    localparam logic [WORD_W-1:0] MIX_L1_A = 64'hC3FBA33BD33BA621;
    localparam logic [WORD_W-1:0] MIX_L1_B = 64'h3FCAB09A08308BA1;
    localparam logic [WORD_W-1:0] LANE_ADD = 64'h34E33AB89DFAA890;

    // per-lane avalanche constants
    localparam logic [WORD_W-1:0] FIN_L0_A = 64'hB91AA8931C3DAB3D;
    localparam logic [WORD_W-1:0] FIN_L0_B = 64'h3185BAFF39A147B3;
    localparam logic [WORD_W-1:0] FIN_L1_A = 64'hC33B0B13DAB0031A;
    localparam logic [WORD_W-1:0] FIN_L1_B = 64'h81CD3A1897B621A3;

    localparam logic [WORD_W-1:0] BLOCK_BYTES = 64'd16;

    // multiplier partial-product steps
    localparam logic [1:0] MUL_STEP_LL = 2'd0;
    localparam logic [1:0] MUL_STEP_LH = 2'd1;
    localparam logic [1:0] MUL_STEP_HL = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MIX_A = 6'b000010,
        S_MIX_B = 6'b000100,
        S_FIN_A = 6'b001000,
        S_FIN_B = 6'b010000,
        S_PUSH  = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        OP_MIX_A = 2'd0,
        OP_MIX_B = 2'd1,
        OP_FIN_A = 2'd2,
        OP_FIN_B = 2'd3
    } op_t;

    typedef struct packed {
        logic capture;    // take the input word
        logic init;       // first word of a message: load seed, clear count
        logic present;    // word carries a block
        logic mul_start;
        logic commit;     // apply the finished product
        op_t  op;
        logic lane;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic mul_done;
    } status_t;

endpackage

@@ sv/tlmh_mul.sv @@
`timescale 1ns / 1ps
// 64x64 multiplier, product mod 2^64, one 32x32 partial product per cycle
// depends on tlmh_pkg

module tlmh_mul
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tlmh_pkg::WORD_W-1:0]  a,
    input  logic [tlmh_pkg::WORD_W-1:0]  b,
    output logic                         busy,
    output logic                         done,
    output logic [tlmh_pkg::WORD_W-1:0]  product
);

    logic [tlmh_pkg::WORD_W-1:0] a_reg, a_next;
    logic [tlmh_pkg::WORD_W-1:0] b_reg, b_next;
    logic [tlmh_pkg::WORD_W-1:0] acc_reg, acc_next;
    logic [1:0]                  step_reg, step_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    logic [tlmh_pkg::HALF_W-1:0] mx, my;
    logic [tlmh_pkg::WORD_W-1:0] m;

    always_comb
    begin
        unique case (step_reg)
            tlmh_pkg::MUL_STEP_LL:
            begin
                mx = a_reg[tlmh_pkg::HALF_W-1:0];
                my = b_reg[tlmh_pkg::HALF_W-1:0];
            end
            tlmh_pkg::MUL_STEP_LH:
            begin
                mx = a_reg[tlmh_pkg::HALF_W-1:0];
                my = b_reg[tlmh_pkg::WORD_W-1:tlmh_pkg::HALF_W];
            end
            default:
            begin
                mx = a_reg[tlmh_pkg::WORD_W-1:tlmh_pkg::HALF_W];
                my = b_reg[tlmh_pkg::HALF_W-1:0];
            end
        endcase
        m = tlmh_pkg::WORD_W'(mx) * tlmh_pkg::WORD_W'(my);
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        priority if (start)
        begin
            a_next    = a;
            b_next    = b;
            step_next = tlmh_pkg::MUL_STEP_LL;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // cross terms only reach the upper half
            if (step_reg == tlmh_pkg::MUL_STEP_LL)
                acc_next = m;
            else
                acc_next = {acc_reg[tlmh_pkg::WORD_W-1:tlmh_pkg::HALF_W]
                            + m[tlmh_pkg::HALF_W-1:0],
                            acc_reg[tlmh_pkg::HALF_W-1:0]};
            if (step_reg == tlmh_pkg::MUL_STEP_HL)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= tlmh_pkg::MUL_STEP_LL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ sv/tlmh_datapath.sv @@
`timescale 1ns / 1ps
// lane hashes, byte count, seed register and result register
// depends on tlmh_pkg and tlmh_mul

module tlmh_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [tlmh_pkg::WORD_W-1:0]  cfg_wdata,
    input  logic [tlmh_pkg::WORD_W-1:0]  word_low,
    input  logic [tlmh_pkg::WORD_W-1:0]  word_high,
    input  tlmh_pkg::cmd_t               cmd,
    output tlmh_pkg::status_t            status,
    output logic [tlmh_pkg::WORD_W-1:0]  hash_value
);

    logic [tlmh_pkg::WORD_W-1:0] seed_reg;
    logic [tlmh_pkg::WORD_W-1:0] wlo_reg, wlo_next;
    logic [tlmh_pkg::WORD_W-1:0] whi_reg, whi_next;
    logic [tlmh_pkg::WORD_W-1:0] h0_reg, h0_next;
    logic [tlmh_pkg::WORD_W-1:0] h1_reg, h1_next;
    logic [tlmh_pkg::WORD_W-1:0] cnt_reg, cnt_next;
    logic [tlmh_pkg::WORD_W-1:0] t_reg, t_next;
    logic [tlmh_pkg::WORD_W-1:0] acc_reg, acc_next;
    logic [tlmh_pkg::WORD_W-1:0] out_reg, out_next;

    logic [tlmh_pkg::WORD_W-1:0] mul_a, mul_b, prod;
    logic [tlmh_pkg::WORD_W-1:0] lane_h, fin_x, mix_y, mix_r, fin_f;
    logic                        mul_busy, mul_done;

    tlmh_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (prod)
    );

    assign status.mul_busy = mul_busy;
    assign status.mul_done = mul_done;

    assign lane_h = cmd.lane ? h1_reg : h0_reg;
    assign fin_x  = lane_h ^ cnt_reg;
    assign mix_y  = lane_h ^ prod;
    assign mix_r  = {mix_y[50:0], mix_y[63:51]};
    assign fin_f  = prod ^ (prod >> 16);

    // operand select
    always_comb
    begin
        unique case (cmd.op)
            tlmh_pkg::OP_MIX_A:
            begin
                mul_a = cmd.lane ? whi_reg : wlo_reg;
                mul_b = cmd.lane ? tlmh_pkg::MIX_L1_A : tlmh_pkg::MIX_L0_A;
            end
            tlmh_pkg::OP_MIX_B:
            begin
                mul_a = t_reg;
                mul_b = cmd.lane ? tlmh_pkg::MIX_L1_B : tlmh_pkg::MIX_L0_B;
            end
            tlmh_pkg::OP_FIN_A:
            begin
                mul_a = fin_x ^ (fin_x >> 16);
                mul_b = cmd.lane ? tlmh_pkg::FIN_L1_A : tlmh_pkg::FIN_L0_A;
            end
            default:
            begin
                mul_a = t_reg;
                mul_b = cmd.lane ? tlmh_pkg::FIN_L1_B : tlmh_pkg::FIN_L0_B;
            end
        endcase
    end

    always_comb
    begin
        wlo_next = wlo_reg;
        whi_next = whi_reg;
        h0_next  = h0_reg;
        h1_next  = h1_reg;
        cnt_next = cnt_reg;
        t_next   = t_reg;
        acc_next = acc_reg;
        out_next = out_reg;

        if (cmd.capture)
        begin
            wlo_next = word_low;
            whi_next = word_high;
            if (cmd.init)
            begin
                h0_next = seed_reg;
                h1_next = seed_reg;
            end
            cnt_next = (cmd.init ? '0 : cnt_reg)
                       + (cmd.present ? tlmh_pkg::BLOCK_BYTES : '0);
        end

        if (cmd.commit)
        begin
            unique case (cmd.op)
                tlmh_pkg::OP_MIX_A:
                begin
                    t_next = {prod[48:0], prod[63:49]};
                end
                tlmh_pkg::OP_MIX_B:
                begin
                    // rotate by 13, times five, plus lane constant
                    if (cmd.lane)
                        h1_next = (mix_r << 2) + mix_r + tlmh_pkg::LANE_ADD;
                    else
                        h0_next = (mix_r << 2) + mix_r + tlmh_pkg::LANE_ADD;
                end
                tlmh_pkg::OP_FIN_A:
                begin
                    t_next = prod ^ (prod >> 13);
                end
                default:
                begin
                    acc_next = cmd.lane ? (acc_reg ^ fin_f) : fin_f;
                end
            endcase
        end

        if (cmd.out_load)
            out_next = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (cfg_we)
            seed_reg <= cfg_wdata;
    end

    always_ff @(posedge clk)
    begin
        wlo_reg <= wlo_next;
        whi_reg <= whi_next;
        h0_reg  <= h0_next;
        h1_reg  <= h1_next;
        cnt_reg <= cnt_next;
        t_reg   <= t_next;
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

    assign hash_value = out_reg;

endmodule

@@ sv/tlmh_ctrl.sv @@
`timescale 1ns / 1ps
// controller: input and output handshakes, message tracking, lane sequencing
// depends on tlmh_pkg

module tlmh_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               block_present,
    input  logic               is_last,
    output logic               out_valid,
    input  logic               out_ready,
    input  tlmh_pkg::status_t  status,
    output tlmh_pkg::cmd_t     cmd
);

    tlmh_pkg::state_t state_reg, state_next;
    logic             lane_reg, lane_next;
    logic             last_reg, last_next;
    logic             in_msg_reg, in_msg_next;
    logic             out_valid_reg, out_valid_next;
    logic             mul_go;

    // launch once per state, apply on done
    assign mul_go = !status.mul_busy && !status.mul_done;

    always_comb
    begin
        state_next = state_reg;
        lane_next  = lane_reg;
        last_next  = last_reg;
        in_msg_next = in_msg_reg;
        in_ready   = 1'b0;

        cmd           = '0;
        cmd.op        = tlmh_pkg::OP_MIX_A;
        cmd.lane      = lane_reg;

        unique case (state_reg)
            tlmh_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                // a word with neither block nor end is dropped
                if (in_valid && (block_present || is_last))
                begin
                    cmd.capture = 1'b1;
                    cmd.init    = !in_msg_reg;
                    cmd.present = block_present;
                    last_next   = is_last;
                    in_msg_next = !is_last;
                    lane_next   = 1'b0;
                    state_next  = block_present ? tlmh_pkg::S_MIX_A : tlmh_pkg::S_FIN_A;
                end
            end
            tlmh_pkg::S_MIX_A:
            begin
                cmd.op        = tlmh_pkg::OP_MIX_A;
                cmd.mul_start = mul_go;
                cmd.commit    = status.mul_done;
                if (status.mul_done)
                    state_next = tlmh_pkg::S_MIX_B;
            end
            tlmh_pkg::S_MIX_B:
            begin
                cmd.op        = tlmh_pkg::OP_MIX_B;
                cmd.mul_start = mul_go;
                cmd.commit    = status.mul_done;
                if (status.mul_done)
                begin
                    priority if (!lane_reg)
                    begin
                        lane_next  = 1'b1;
                        state_next = tlmh_pkg::S_MIX_A;
                    end
                    else if (last_reg)
                    begin
                        lane_next  = 1'b0;
                        state_next = tlmh_pkg::S_FIN_A;
                    end
                    else
                    begin
                        state_next = tlmh_pkg::S_IDLE;
                    end
                end
            end
            tlmh_pkg::S_FIN_A:
            begin
                cmd.op        = tlmh_pkg::OP_FIN_A;
                cmd.mul_start = mul_go;
                cmd.commit    = status.mul_done;
                if (status.mul_done)
                    state_next = tlmh_pkg::S_FIN_B;
            end
            tlmh_pkg::S_FIN_B:
            begin
                cmd.op        = tlmh_pkg::OP_FIN_B;
                cmd.mul_start = mul_go;
                cmd.commit    = status.mul_done;
                if (status.mul_done)
                begin
                    if (!lane_reg)
                    begin
                        lane_next  = 1'b1;
                        state_next = tlmh_pkg::S_FIN_A;
                    end
                    else
                    begin
                        state_next = tlmh_pkg::S_PUSH;
                    end
                end
            end
            tlmh_pkg::S_PUSH:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = tlmh_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tlmh_pkg::S_IDLE;
            end
        endcase

        out_valid_next = cmd.out_load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlmh_pkg::S_IDLE;
            lane_reg      <= 1'b0;
            last_reg      <= 1'b0;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lane_reg      <= lane_next;
            last_reg      <= last_next;
            in_msg_reg    <= in_msg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ sv/two_lane_mix_hash_64.sv @@
`timescale 1ns / 1ps
// two-lane 64-bit mixing hash, one 16-byte block per input word.
// a block word takes 4 lane multiplies on the one shared 32x32 multiplier, after
// the accept state; a last word adds avalanche and output load, and an end word
// without block goes straight to the avalanche.
// a finished hash waits in the output register while the next word is taken.
// rst_n clears control state and the seed asynchronously; no clearing pass.

module two_lane_mix_hash_64
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] word_low,
    input  logic [63:0] word_high,
    input  logic        block_present,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] hash_value
);

    tlmh_pkg::cmd_t    cmd;
    tlmh_pkg::status_t status;

    tlmh_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .block_present (block_present),
        .is_last       (is_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .cmd           (cmd)
    );

    tlmh_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .word_low   (word_low),
        .word_high  (word_high),
        .cmd        (cmd),
        .status     (status),
        .hash_value (hash_value)
    );

    // the multiplier is never running while a word can be taken
    a_idle_mul: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!status.mul_busy && !status.mul_done))
        else $error("multiplier active while accepting a word");

    // a dropped word leaves the block ready
    a_drop_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !block_present && !is_last) |=> in_ready)
        else $error("empty non-final word started work");

    // a word with a block starts the lane work
    a_block_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && block_present) |=> !in_ready)
        else $error("block word did not start mixing");

    // result is loaded only when the output slot is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("result register overwritten");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for two_lane_mix_hash_64: drives messages of 16-byte blocks
// through seed changes and idling, and checks each hash against an in-bench predictor
// depends on tlmh_pkg and two_lane_mix_hash_64

module testbench;

    import tlmh_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned SETTLE_CYCLES = 50;
    localparam int unsigned HOLD_CYCLES = 700;
    localparam int unsigned PHASE_WORDS = 265;
    localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

    typedef enum logic [1:0] {
        RCV_ALWAYS = 2'd0,
        RCV_MASK   = 2'd1,
        RCV_RANDOM = 2'd2
    } rcv_mode_t;

    typedef struct {
        logic [WORD_W-1:0] w_lo;
        logic [WORD_W-1:0] w_hi;
        logic              has_block;
        logic              ends;
    } msg_word_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [63:0]       cfg_wdata = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [63:0]       word_low = '0;
    logic [63:0]       word_high = '0;
    logic              block_present = 1'b0;
    logic              is_last = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [63:0]       hash_value;

    msg_word_t         pending_words[$];
    logic [WORD_W-1:0] expected_hashes[$];

    // predictor state
    logic [WORD_W-1:0] seed_setting = '0;
    logic [WORD_W-1:0] hash_lo = '0;
    logic [WORD_W-1:0] hash_hi = '0;
    logic [WORD_W-1:0] bytes_seen = '0;
    logic              msg_open = 1'b0;

    logic              in_fire = 1'b0;
    int unsigned       burst_left = 0;
    int unsigned       gap_left = 0;
    int unsigned       burst_max = 8;
    int unsigned       gap_max = 0;
    rcv_mode_t         rcv_mode = RCV_ALWAYS;
    logic [15:0]       rcv_mask = 16'hFFFF;
    logic [3:0]        rcv_tick = '0;
    logic              rcv_hold = 1'b0;
    logic              pressure_go = 1'b0;

    int unsigned       cycle_count = 0;
    int unsigned       error_count = 0;
    int unsigned       words_taken = 0;
    int unsigned       hashes_checked = 0;
    int unsigned       seed_writes = 0;

    two_lane_mix_hash_64 u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .word_low      (word_low),
        .word_high     (word_high),
        .block_present (block_present),
        .is_last       (is_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hash_value    (hash_value)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%t timeout after %0d cycles, %0d hashes outstanding", $realtime,
                     cycle_count, expected_hashes.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [WORD_W-1:0] lane_absorb(logic [WORD_W-1:0] h,
            logic [WORD_W-1:0] w, logic [WORD_W-1:0] ka, logic [WORD_W-1:0] kb);
        logic [WORD_W-1:0] m;
        m = w * ka;
        m = {m[48:0], m[63:49]};
        m = m * kb;
        h = h ^ m;
        h = {h[50:0], h[63:51]};
        return h * 64'd5 + LANE_ADD;
    endfunction

    function automatic logic [WORD_W-1:0] lane_avalanche(logic [WORD_W-1:0] h,
            logic [WORD_W-1:0] len, logic [WORD_W-1:0] ka, logic [WORD_W-1:0] kb);
        h = h ^ len;
        h = h ^ (h >> 16);
        h = h * ka;
        h = h ^ (h >> 13);
        h = h * kb;
        h = h ^ (h >> 16);
        return h;
    endfunction

    task automatic absorb_word(msg_word_t w);
        // neither block nor end: ignored, does not open a message
        if (!w.has_block && !w.ends)
            return;
        if (!msg_open)
        begin
            hash_lo = seed_setting;
            hash_hi = seed_setting;
            bytes_seen = '0;
            msg_open = 1'b1;
        end
        if (w.has_block)
        begin
            hash_lo = lane_absorb(hash_lo, w.w_lo, MIX_L0_A, MIX_L0_B);
            hash_hi = lane_absorb(hash_hi, w.w_hi, MIX_L1_A, MIX_L1_B);
            bytes_seen = bytes_seen + BLOCK_BYTES;
        end
        if (w.ends)
        begin
            expected_hashes.push_back(
                lane_avalanche(hash_lo, bytes_seen, FIN_L0_A, FIN_L0_B) ^
                lane_avalanche(hash_hi, bytes_seen, FIN_L1_A, FIN_L1_B));
            msg_open = 1'b0;
        end
    endtask

    // monitor: check results, then predict from the accepted word
    always @(posedge clk)
    begin : watch_ports
        msg_word_t w;
        logic [WORD_W-1:0] want;
        in_fire <= rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            hashes_checked++;
            if (expected_hashes.size() == 0)
            begin
                error_count++;
                $display("%t unexpected hash: expected none, actual %h", $realtime,
                         hash_value);
            end
            else
            begin
                want = expected_hashes.pop_front();
                if (hash_value !== want)
                begin
                    error_count++;
                    $display("%t hash_value mismatch: expected %h, actual %h", $realtime,
                             want, hash_value);
                end
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            w.w_lo = word_low;
            w.w_hi = word_high;
            w.has_block = block_present;
            w.ends = is_last;
            words_taken++;
            absorb_word(w);
        end
    end

    // sender: bursts of words separated by random gaps
    always @(negedge clk)
    begin : drive_words
        msg_word_t w;
        if (in_valid && !in_fire)
        begin
            // word still waiting for acceptance
        end
        else if (gap_left != 0)
        begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (rst_n && pending_words.size() != 0)
        begin
            w = pending_words.pop_front();
            word_low <= w.w_lo;
            word_high <= w.w_hi;
            block_present <= w.has_block;
            is_last <= w.ends;
            in_valid <= 1'b1;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, burst_max);
                gap_left <= (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            end
            else
                burst_left <= burst_left - 1;
        end
        else
            in_valid <= 1'b0;
    end

    // receiver: stalls on a rotating mask or at random, plus the long hold-off
    always @(negedge clk)
    begin
        rcv_tick <= rcv_tick + 4'd1;
        if (!rst_n || rcv_hold)
            out_ready <= 1'b0;
        else
            case (rcv_mode)
                RCV_MASK:   out_ready <= rcv_mask[rcv_tick];
                RCV_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
                default:    out_ready <= 1'b1;
            endcase
    end

    // long hold-off so the block backs up into its input
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        rcv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rcv_hold <= 1'b0;
    end

    function automatic logic [WORD_W-1:0] rand64();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_word(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi,
            logic present, logic ends);
        msg_word_t w;
        w.w_lo = lo;
        w.w_hi = hi;
        w.has_block = present;
        w.ends = ends;
        pending_words.push_back(w);
    endtask

    // zero blocks with an end alone is an empty message
    task automatic add_message(int unsigned n_blocks, bit end_alone);
        for (int unsigned i = 0; i < n_blocks; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                push_word(rand64(), rand64(), 1'b0, 1'b0);
            push_word(rand64(), rand64(), 1'b1, !end_alone && (i == n_blocks - 1));
        end
        if (end_alone)
            push_word(rand64(), rand64(), 1'b0, 1'b1);
    endtask

    task automatic add_random_words(int unsigned target);
        int unsigned added;
        int unsigned n;
        bit end_alone;
        added = 0;
        while (added < target)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                add_message(0, 1'b1);
                added += 1;
            end
            else if ($urandom_range(0, 11) == 0)
                push_word(rand64(), rand64(), 1'b0, 1'b0);
            else
            begin
                n = ($urandom_range(0, 24) == 0) ? $urandom_range(5, 16)
                                                 : $urandom_range(1, 4);
                end_alone = ($urandom_range(0, 6) == 0);
                add_message(n, end_alone);
                added += n + (end_alone ? 1 : 0);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_hashes.size() != 0)
            @(posedge clk);
        // a block word without result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(logic [WORD_W-1:0] value);
        @(negedge clk);
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        seed_setting = value;
        seed_writes++;
    endtask

    task automatic set_idling(int unsigned g_max, int unsigned b_max, rcv_mode_t mode);
        gap_max = g_max;
        burst_max = b_max;
        rcv_mode = mode;
        rcv_mask = 16'($urandom) | 16'h0001;
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        // directed words, seed zero
        write_seed('0);
        set_idling(3, 4, RCV_MASK);
        push_word(ALL_ONES, ALL_ONES, 1'b0, 1'b1);
        push_word(ALL_ONES, ALL_ONES, 1'b0, 1'b0);
        push_word('0, '0, 1'b1, 1'b1);
        push_word(ALL_ONES, ALL_ONES, 1'b1, 1'b1);
        push_word(ALL_ONES, '0, 1'b1, 1'b0);
        push_word('0, ALL_ONES, 1'b1, 1'b1);
        push_word(64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 1'b1, 1'b0);
        push_word(64'h5A5A_5A5A_5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 1'b0);
        push_word(rand64(), rand64(), 1'b0, 1'b0);
        push_word(rand64(), rand64(), 1'b0, 1'b1);
        push_word(64'd1, 64'h8000_0000_0000_0000, 1'b1, 1'b1);
        push_word(64'h8000_0000_0000_0000, 64'd1, 1'b1, 1'b1);
        add_message(4, 1'b0);
        // leave a message open across the seed change
        push_word(rand64(), rand64(), 1'b1, 1'b0);
        wait_drained();

        write_seed(ALL_ONES);
        set_idling(10, 12, RCV_MASK);
        push_word(rand64(), rand64(), 1'b1, 1'b1);
        push_word(rand64(), rand64(), 1'b0, 1'b1);
        add_random_words(PHASE_WORDS);
        wait_drained();

        write_seed({$urandom, $urandom});
        set_idling(3, 16, RCV_RANDOM);
        pressure_go = 1'b1;
        add_random_words(PHASE_WORDS);
        wait_drained();

        write_seed(64'd1);
        set_idling(0, 16, RCV_ALWAYS);
        add_random_words(PHASE_WORDS);
        wait_drained();

        write_seed(64'h8000_0000_0000_0000);
        set_idling(12, 3, RCV_RANDOM);
        add_random_words(PHASE_WORDS);
        wait_drained();

        write_seed({$urandom, $urandom});
        set_idling(5, 8, RCV_MASK);
        add_random_words(PHASE_WORDS);
        wait_drained();

        $display("run covered %0d accepted input words and %0d checked hashes", words_taken,
                 hashes_checked);
        $display("under %0d seed values, with sender gaps, receiver stalls and one long hold",
                 seed_writes);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
